[design/ik_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_pkg
// Shared widths, constants and types of the two-link inverse kinematics unit.
// ----------------------------------------------------------------------------
package ik_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned LenW      = 31;
  localparam int unsigned HipW      = 26;
  localparam int unsigned KneeW     = 24;
  localparam int unsigned AngW      = 34;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned QW        = 31;
  localparam int unsigned RemW      = 63;
  localparam int unsigned RadW      = 61;
  localparam int unsigned DivSteps  = 31;
  localparam int unsigned SqrtSteps = 31;
  localparam int unsigned OpW       = 64;
  localparam int unsigned NumLanes  = 3;
  localparam int unsigned LaneKnee  = 0;
  localparam int unsigned LaneAlpha = 1;
  localparam int unsigned LaneBeta  = 2;

  localparam logic [LenW-1:0]        LenReset = 31'd13107;
  localparam logic [QW-1:0]          OneQ30   = 31'h4000_0000;
  localparam logic [RadW-1:0]        OneQ60   = 61'h1000_0000_0000_0000;
  localparam logic signed [AngW-1:0] Deg180   = 34'sd3019898880;

  localparam logic [29:0] AtanTab [32] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
    30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
    30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,       30'd57,
    30'd29,        30'd14,        30'd7,         30'd4,         30'd2,
    30'd1,         30'd0
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgThigh = 2'd0,
    CfgCalf  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] z;
    logic                     unreach;
    logic                     neg;
  } div_side_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] z;
    logic                     unreach;
    logic                     neg;
    logic [QW-1:0]            qc;
  } sqrt_side_t;

endpackage

[design/ik_target_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_target_if
// Request channel carrying one foot target.
// ----------------------------------------------------------------------------
interface ik_target_if;
  import ik_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] target_x;
  logic signed [CoordW-1:0] target_z;
  modport source (output valid, output target_x, output target_z, input ready);
  modport sink   (input valid, input target_x, input target_z, output ready);
endinterface

[design/ik_joint_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_joint_if
// Request channel carrying one pair of joint angles.
// ----------------------------------------------------------------------------
interface ik_joint_if;
  import ik_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [HipW-1:0] hip_angle;
  logic [KneeW-1:0]       knee_angle;
  logic                   reachable;
  modport source (output valid, output hip_angle, output knee_angle, output reachable,
                  input ready);
  modport sink   (input valid, input hip_angle, input knee_angle, input reachable,
                  output ready);
endinterface

[design/ik_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_divider
// Restoring divider, one quotient bit per stage: q = floor(a * 2^30 / den).
// ----------------------------------------------------------------------------
module ik_divider #(
  parameter int unsigned SideW = 66
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [ik_pkg::RemW-1:0]  a_i,
  input  logic [ik_pkg::RemW-1:0]  den_i,
  input  logic [SideW-1:0]         side_i,
  output logic                     valid_o,
  output logic [ik_pkg::QW-1:0]    q_o,
  output logic [SideW-1:0]         side_o
);
  import ik_pkg::*;

  logic [RemW-1:0]  r_q    [DivSteps];
  logic [QW-1:0]    q_q    [DivSteps];
  logic [SideW-1:0] side_q [DivSteps];
  logic             vld_q  [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [RemW:0]    rin;
    logic [QW-1:0]    qin;
    logic [RemW:0]    rsub;
    logic             ge;
    logic [SideW-1:0] sin;
    logic             vin;

    if (k == 0) begin : g_first
      assign rin = {1'b0, a_i};
      assign qin = '0;
      assign sin = side_i;
      assign vin = valid_i;
    end else begin : g_next
      assign rin = {r_q[k-1], 1'b0};
      assign qin = {q_q[k-1][QW-2:0], 1'b0};
      assign sin = side_q[k-1];
      assign vin = vld_q[k-1];
    end

    assign ge   = rin >= {1'b0, den_i};
    assign rsub = rin - {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? rsub[RemW-1:0] : rin[RemW-1:0];
        q_q[k]    <= {qin[QW-1:1], ge};
        side_q[k] <= sin;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign q_o     = q_q[DivSteps-1];
  assign side_o  = side_q[DivSteps-1];

endmodule

[design/ik_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_isqrt
// Floor square root of a 61-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module ik_isqrt #(
  parameter int unsigned SideW = 97
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [ik_pkg::RadW-1:0]  rad_i,
  input  logic [SideW-1:0]         side_i,
  output logic                     valid_o,
  output logic [ik_pkg::QW-1:0]    root_o,
  output logic [SideW-1:0]         side_o
);
  import ik_pkg::*;

  logic [RadW-1:0]  v_q    [SqrtSteps];
  logic [RadW:0]    res_q  [SqrtSteps];
  logic [SideW-1:0] side_q [SqrtSteps];
  logic             vld_q  [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [RadW:0] Bit = (RadW+1)'(1) << (RadW - 1 - 2 * k);
    logic [RadW-1:0]  vin;
    logic [RadW:0]    rin;
    logic [RadW:0]    t;
    logic             ge;
    logic [SideW-1:0] sdin;
    logic             vdin;

    if (k == 0) begin : g_first
      assign vin  = rad_i;
      assign rin  = '0;
      assign sdin = side_i;
      assign vdin = valid_i;
    end else begin : g_next
      assign vin  = v_q[k-1];
      assign rin  = res_q[k-1];
      assign sdin = side_q[k-1];
      assign vdin = vld_q[k-1];
    end

    assign t  = rin + Bit;
    assign ge = {1'b0, vin} >= t;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]    <= ge ? vin - t[RadW-1:0] : vin;
        res_q[k]  <= ge ? (rin >> 1) + Bit : rin >> 1;
        side_q[k] <= sdin;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vdin;
      end
    end
  end

  assign valid_o = vld_q[SqrtSteps-1];
  assign root_o  = res_q[SqrtSteps-1][QW-1:0];
  assign side_o  = side_q[SqrtSteps-1];

endmodule

[design/ik_atan2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_atan2
// Pipelined vectoring CORDIC atan2 lanes: magnitude, three normalise stages,
// one rotation per stage, quadrant fix-up. Angles in degrees * 2^24.
// ----------------------------------------------------------------------------
module ik_atan2 #(
  parameter int unsigned Stages = 24,
  parameter int unsigned Lanes  = 3,
  parameter int unsigned SideW  = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [ik_pkg::OpW-1:0]   y_i   [Lanes],
  input  logic signed [ik_pkg::OpW-1:0]   x_i   [Lanes],
  input  logic [SideW-1:0]                side_i,
  output logic                            valid_o,
  output logic signed [ik_pkg::AngW-1:0]  ang_o [Lanes],
  output logic [SideW-1:0]                side_o
);
  import ik_pkg::*;

  localparam int unsigned Depth = Stages + 5;
  localparam int unsigned FlN   = Stages + 4;
  localparam int unsigned CW    = 33;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } lane_fl_t;

  logic [OpW-1:0]          mx_q [Lanes][4];
  logic [OpW-1:0]          my_q [Lanes][4];
  lane_fl_t                fl_q [Lanes][FlN];
  logic signed [CW-1:0]    cx_q [Lanes][Stages];
  logic signed [CW-1:0]    cy_q [Lanes][Stages];
  logic signed [AngW-1:0]  az_q [Lanes][Stages];
  logic signed [AngW-1:0]  ang_q [Lanes];
  logic                    vld_q  [Depth];
  logic [SideW-1:0]        side_q [Depth];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mx_q[l][0]      <= x_i[l][OpW-1] ? OpW'(-x_i[l]) : OpW'(x_i[l]);
        my_q[l][0]      <= y_i[l][OpW-1] ? OpW'(-y_i[l]) : OpW'(y_i[l]);
        fl_q[l][0].xneg <= x_i[l][OpW-1];
        fl_q[l][0].yneg <= y_i[l][OpW-1];
        fl_q[l][0].zero <= (x_i[l] == '0) && (y_i[l] == '0);
      end
    end

    for (genvar k = 1; k < 4; k++) begin : g_norm
      localparam int unsigned ShA = 1 << (7 - 2 * k);
      localparam int unsigned ShB = ShA >> 1;
      logic [OpW-1:0] a1, b1, a2, b2;

      always_comb begin
        a1 = mx_q[l][k-1];
        b1 = my_q[l][k-1];
        if (((a1 | b1) >> (OpW - ShA)) == '0) begin
          a1 = a1 << ShA;
          b1 = b1 << ShA;
        end
        a2 = a1;
        b2 = b1;
        if (((a1 | b1) >> (OpW - ShB)) == '0) begin
          a2 = a1 << ShB;
          b2 = b1 << ShB;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          mx_q[l][k] <= a2;
          my_q[l][k] <= b2;
          fl_q[l][k] <= fl_q[l][k-1];
        end
      end
    end

    for (genvar j = 0; j < Stages; j++) begin : g_rot
      logic signed [CW-1:0]   cxi, cyi;
      logic signed [AngW-1:0] azi, step;

      if (j == 0) begin : g_first
        assign cxi = signed'({3'b000, mx_q[l][3][OpW-1:OpW-30]});
        assign cyi = signed'({3'b000, my_q[l][3][OpW-1:OpW-30]});
        assign azi = '0;
      end else begin : g_next
        assign cxi = cx_q[l][j-1];
        assign cyi = cy_q[l][j-1];
        assign azi = az_q[l][j-1];
      end

      assign step = signed'(AngW'(AtanTab[j]));

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!cyi[CW-1]) begin
            cx_q[l][j] <= cxi + (cyi >>> j);
            cy_q[l][j] <= cyi - (cxi >>> j);
            az_q[l][j] <= azi + step;
          end else begin
            cx_q[l][j] <= cxi - (cyi >>> j);
            cy_q[l][j] <= cyi + (cxi >>> j);
            az_q[l][j] <= azi - step;
          end
          fl_q[l][4+j] <= fl_q[l][3+j];
        end
      end
    end

    logic signed [AngW-1:0] zf;
    always_comb begin
      zf = az_q[l][Stages-1];
      if (fl_q[l][FlN-1].xneg) begin
        zf = Deg180 - zf;
      end
      if (fl_q[l][FlN-1].yneg) begin
        zf = -zf;
      end
      if (fl_q[l][FlN-1].zero) begin
        zf = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ang_q[l] <= zf;
      end
    end

    assign ang_o[l] = ang_q[l];
  end

  for (genvar n = 0; n < Depth; n++) begin : g_ctl
    logic             vin;
    logic [SideW-1:0] sin;

    if (n == 0) begin : g_first
      assign vin = valid_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[n-1];
      assign sin = side_q[n-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[n] <= 1'b0;
      end else if (en_i) begin
        vld_q[n] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[n] <= sin;
      end
    end
  end

  assign valid_o = vld_q[Depth-1];
  assign side_o  = side_q[Depth-1];

endmodule

[design/two_link_inverse_kinematics_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_unit
// Hip and knee angles of a two-link leg for a foot target, fully pipelined.
//
//   channel    dir  handshake      payload
//   target_i   in   valid/ready    target_x, target_z (Q16.16)
//   joint_o    out  valid/ready    hip_angle, knee_angle (Q.16 deg), reachable
//   cfg        in   cfg_we_i       cfg_idx_i, cfg_data_i (link lengths)
//
// One request per cycle unless the output stalls; the path runs through the
// 31-stage divider, the 31-stage square root and the CORDIC rotations.
// All stages advance together; a stalled output holds the whole pipe.
// Reset clears the valid bits and loads both lengths with 13107.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_unit #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ik_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ik_pkg::LenW-1:0]      cfg_data_i,
  ik_target_if.sink                    target_i,
  ik_joint_if.source                   joint_o
);
  import ik_pkg::*;

  logic en;
  logic out_valid_q;

  assign en             = !out_valid_q || joint_o.ready;
  assign target_i.ready = en;

  // configuration
  logic [LenW-1:0] thigh_q, calf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thigh_q <= LenReset;
      calf_q  <= LenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgThigh: thigh_q <= cfg_data_i;
        CfgCalf:  calf_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0]     sum;
  logic [LenW-1:0] dif;
  logic [61:0]     sq_t, sq_c, prod_tc;
  logic [63:0]     sumsq_q;
  logic [61:0]     difsq_q;
  logic [62:0]     lsq_q;
  logic [RemW-1:0] den_q;
  logic            lz_q;

  assign sum     = {1'b0, thigh_q} + {1'b0, calf_q};
  assign dif     = (thigh_q > calf_q) ? thigh_q - calf_q : calf_q - thigh_q;
  assign sq_t    = {31'b0, thigh_q} * {31'b0, thigh_q};
  assign sq_c    = {31'b0, calf_q} * {31'b0, calf_q};
  assign prod_tc = {31'b0, thigh_q} * {31'b0, calf_q};

  always_ff @(posedge clk_i) begin
    sumsq_q <= {32'b0, sum} * {32'b0, sum};
    difsq_q <= {31'b0, dif} * {31'b0, dif};
    lsq_q   <= {1'b0, sq_t} + {1'b0, sq_c};
    den_q   <= {prod_tc, 1'b0};
    lz_q    <= (thigh_q == '0) || (calf_q == '0);
  end

  // stage 1: squares of the target magnitudes
  logic [CoordW-1:0]        ux, uz;
  logic                     v1_q;
  logic signed [CoordW-1:0] x1_q, z1_q;
  logic [63:0]              sqx1_q, sqz1_q;

  assign ux = target_i.target_x[CoordW-1] ? ~target_i.target_x + 32'd1 : target_i.target_x;
  assign uz = target_i.target_z[CoordW-1] ? ~target_i.target_z + 32'd1 : target_i.target_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= target_i.target_x;
      z1_q   <= target_i.target_z;
      sqx1_q <= {32'b0, ux} * {32'b0, ux};
      sqz1_q <= {32'b0, uz} * {32'b0, uz};
    end
  end

  // stage 2: squared distance
  logic                     v2_q;
  logic signed [CoordW-1:0] x2_q, z2_q;
  logic [63:0]              dsq2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q   <= x1_q;
      z2_q   <= z1_q;
      dsq2_q <= sqx1_q + sqz1_q;
    end
  end

  // stage 3: workspace test and clamped cosine numerator
  logic            v3_q;
  logic            neg3;
  logic [63:0]     adiff;
  logic [RemW-1:0] a3_q;
  div_side_t       dside3_q;

  assign neg3  = dsq2_q < {1'b0, lsq_q};
  assign adiff = neg3 ? {1'b0, lsq_q} - dsq2_q : dsq2_q - {1'b0, lsq_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q             <= (adiff > {1'b0, den_q}) ? den_q : adiff[RemW-1:0];
      dside3_q.x       <= x2_q;
      dside3_q.z       <= z2_q;
      dside3_q.neg     <= neg3;
      dside3_q.unreach <= lz_q || (dsq2_q > sumsq_q) || (dsq2_q < {2'b0, difsq_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= target_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // cosine of the knee
  logic                          div_vld;
  logic [QW-1:0]                 div_q;
  logic [$bits(div_side_t)-1:0]  div_side_bits;
  div_side_t                     div_side;

  ik_divider #(
    .SideW ($bits(div_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .a_i     (a3_q),
    .den_i   (den_q),
    .side_i  (dside3_q),
    .valid_o (div_vld),
    .q_o     (div_q),
    .side_o  (div_side_bits)
  );

  assign div_side = div_side_t'(div_side_bits);

  // stage 4: clamp and square the cosine
  logic          v4_q;
  logic [QW-1:0] qc4;
  logic [61:0]   qsq4;
  logic [RadW-1:0] qsq4_q;
  sqrt_side_t    sside4_q;

  assign qc4  = (div_q > OneQ30) ? OneQ30 : div_q;
  assign qsq4 = {31'b0, qc4} * {31'b0, qc4};

  always_ff @(posedge clk_i) begin
    if (en) begin
      qsq4_q           <= qsq4[RadW-1:0];
      sside4_q.x       <= div_side.x;
      sside4_q.z       <= div_side.z;
      sside4_q.unreach <= div_side.unreach;
      sside4_q.neg     <= div_side.neg;
      sside4_q.qc      <= qc4;
    end
  end

  // sine of the knee
  logic                          sq_vld;
  logic [QW-1:0]                 sq_root;
  logic [$bits(sqrt_side_t)-1:0] sq_side_bits;
  sqrt_side_t                    sq_side;

  ik_isqrt #(
    .SideW ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .rad_i   (OneQ60 - qsq4_q),
    .side_i  (sside4_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side_bits)
  );

  assign sq_side = sqrt_side_t'(sq_side_bits);

  // stage 5: signed cosine and link products
  logic                     v5_q;
  logic signed [31:0]       c5;
  logic signed [63:0]       l2c5;
  logic signed [31:0]       c5_q;
  logic [QW-1:0]            s5_q;
  logic [61:0]              l2s5_q;
  logic signed [63:0]       l2c5_q;
  logic signed [CoordW-1:0] x5_q, z5_q;
  logic                     un5_q;

  assign c5   = sq_side.neg ? -$signed({1'b0, sq_side.qc}) : $signed({1'b0, sq_side.qc});
  assign l2c5 = $signed({1'b0, calf_q}) * c5;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q   <= c5;
      s5_q   <= sq_root;
      l2s5_q <= {31'b0, calf_q} * {31'b0, sq_root};
      l2c5_q <= l2c5;
      x5_q   <= sq_side.x;
      z5_q   <= sq_side.z;
      un5_q  <= sq_side.unreach;
    end
  end

  // stage 6: operands of the three atan2 lanes
  logic                   v6_q;
  logic signed [OpW-1:0]  ay6_q [NumLanes];
  logic signed [OpW-1:0]  ax6_q [NumLanes];
  logic                   un6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ay6_q[LaneKnee]  <= $signed({33'b0, s5_q});
      ax6_q[LaneKnee]  <= {{32{c5_q[31]}}, c5_q};
      ay6_q[LaneAlpha] <= {{32{x5_q[CoordW-1]}}, x5_q};
      ax6_q[LaneAlpha] <= -{{32{z5_q[CoordW-1]}}, z5_q};
      ay6_q[LaneBeta]  <= $signed({2'b0, l2s5_q});
      ax6_q[LaneBeta]  <= $signed({3'b0, thigh_q, 30'b0}) + l2c5_q;
      un6_q            <= un5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v4_q <= div_vld;
      v5_q <= sq_vld;
      v6_q <= v5_q;
    end
  end

  // angles
  logic                   at_vld;
  logic signed [AngW-1:0] ang [NumLanes];
  logic                   at_un;

  ik_atan2 #(
    .Stages (CORDIC_STAGES),
    .Lanes  (NumLanes),
    .SideW  (1)
  ) u_atan2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .y_i     (ay6_q),
    .x_i     (ax6_q),
    .side_i  (un6_q),
    .valid_o (at_vld),
    .ang_o   (ang),
    .side_o  (at_un)
  );

  // output register: hip difference and rounding to Q.16
  logic signed [AngW:0]   hip, hip_r;
  logic signed [AngW-1:0] knee_r;
  logic signed [HipW-1:0] hip_q;
  logic [KneeW-1:0]       knee_q;
  logic                   reach_q;

  assign hip    = {ang[LaneAlpha][AngW-1], ang[LaneAlpha]} - {ang[LaneBeta][AngW-1], ang[LaneBeta]};
  assign hip_r  = hip + 35'sd128;
  assign knee_r = ang[LaneKnee] + 34'sd128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= at_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hip_q   <= at_un ? '0 : hip_r[HipW+7:8];
      knee_q  <= at_un ? '0 : knee_r[KneeW+7:8];
      reach_q <= !at_un;
    end
  end

  assign joint_o.valid      = out_valid_q;
  assign joint_o.hip_angle  = hip_q;
  assign joint_o.knee_angle = knee_q;
  assign joint_o.reachable  = reach_q;

  a_unreach_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    joint_o.valid && !joint_o.reachable |-> joint_o.hip_angle == '0 && joint_o.knee_angle == '0)
    else $error("unreachable result with non-zero angles");

  a_accept_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    target_i.valid && target_i.ready && joint_o.valid |-> joint_o.ready)
    else $error("request taken while the output is stalled");

  a_cfg_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(thigh_q) && $stable(calf_q))
    else $error("link length changed without a write");

endmodule

[test/two_link_inverse_kinematics_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_unit_tb
// Self-checking bench for the two-link leg solver. Foot targets are streamed
// through the target channel under several link-length settings. Each
// accepted target is solved by a bit-exact fixed-point model of the law of
// cosines, the square root and the CORDIC atan2 steps. Each joint response is
// compared, field by field, with the oldest predicted one. Sender and receiver
// idle at random, then the other way round, then not at all.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_unit_tb;
  import ik_pkg::*;

  localparam int unsigned Stages      = 24;
  localparam int unsigned DrainCycles = 130;
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned PhaseItems  = 140;
  localparam int unsigned NumPhases   = 8;

  typedef struct packed {
    logic signed [HipW-1:0] hip;
    logic [KneeW-1:0]       knee;
    logic                   reach;
  } joint_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] z;
  } target_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [LenW-1:0] cfg_data_i;

  ik_target_if tgt ();
  ik_joint_if  jnt ();

  two_link_inverse_kinematics_unit #(.CORDIC_STAGES(Stages)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .target_i   (tgt.sink),
    .joint_o    (jnt.source)
  );

  target_t     pending_targets[$];
  joint_t      expected_joints[$];
  longint unsigned upper_len;
  longint unsigned lower_len;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          mismatches;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint atan2_deg24(longint y, longint x);
    longint unsigned ax, ay, m;
    longint cx, cy, ang, dx, dy;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    ang = 0;
    if (ax == 0 && ay == 0) return 0;
    m = (ax > ay) ? ax : ay;
    while (m >= 64'd1073741824) begin
      ax = ax >> 1; ay = ay >> 1; m = m >> 1;
    end
    while (m < 64'd536870912) begin
      ax = ax << 1; ay = ay << 1; m = m << 1;
    end
    cx = longint'(ax);
    cy = longint'(ay);
    for (int i = 0; i < Stages; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx; cy = cy - dy; ang = ang + longint'(AtanTab[i]);
      end else begin
        cx = cx - dx; cy = cy + dy; ang = ang - longint'(AtanTab[i]);
      end
    end
    if (x < 0) ang = longint'(Deg180) - ang;
    if (y < 0) ang = -ang;
    return ang;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic joint_t solve_leg(logic signed [CoordW-1:0] tx,
                                       logic signed [CoordW-1:0] tz);
    joint_t j;
    longint x, z, c, knee, alpha, beta, hip;
    longint unsigned ux, uz, dsq, sum, dif, lsq, den, a, r, q, s;
    logic neg;
    j = '0;
    x = longint'(tx);
    z = longint'(tz);
    ux = (x < 0) ? -x : x;
    uz = (z < 0) ? -z : z;
    dsq = ux * ux + uz * uz;
    sum = upper_len + lower_len;
    dif = (upper_len > lower_len) ? upper_len - lower_len : lower_len - upper_len;
    if (upper_len == 0 || lower_len == 0 || dsq > sum * sum || dsq < dif * dif) return j;
    lsq = upper_len * upper_len + lower_len * lower_len;
    den = 2 * upper_len * lower_len;
    neg = dsq < lsq;
    a = neg ? lsq - dsq : dsq - lsq;
    if (a > den) a = den;
    q = 0;
    r = a;
    if (r >= den) begin
      q = 1; r = r - den;
    end
    for (int i = 0; i < 30; i++) begin
      r = r << 1; q = q << 1;
      if (r >= den) begin
        r = r - den; q = q | 1;
      end
    end
    if (q > 64'd1073741824) q = 64'd1073741824;
    s = floor_sqrt((64'd1 << 60) - q * q);
    c = neg ? -longint'(q) : longint'(q);
    knee = atan2_deg24(longint'(s), c);
    alpha = atan2_deg24(x, -z);
    beta = atan2_deg24(longint'(lower_len * s),
                       longint'(upper_len << 30) + longint'(lower_len) * c);
    hip = alpha - beta;
    j.hip = HipW'((hip + 128) >>> 8);
    j.knee = KneeW'((knee + 128) >>> 8);
    j.reach = 1'b1;
    return j;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk_i) begin : drv
    target_t t;
    if (rst_ni) begin
      if (tgt.valid && tgt.ready)
        expected_joints.push_back(solve_leg(tgt.target_x, tgt.target_z));
      if (!tgt.valid || tgt.ready) begin
        if (pending_targets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          t = pending_targets.pop_front();
          tgt.valid <= 1'b1;
          tgt.target_x <= t.x;
          tgt.target_z <= t.z;
        end else begin
          tgt.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) jnt.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin : mon
    joint_t e;
    if (rst_ni && jnt.valid && jnt.ready) begin
      if (expected_joints.size() == 0) begin
        report_mismatch("unexpected response", 0, 0);
      end else begin
        e = expected_joints.pop_front();
        if (jnt.hip_angle !== e.hip) report_mismatch("hip_angle", jnt.hip_angle, e.hip);
        if (jnt.knee_angle !== e.knee) report_mismatch("knee_angle", jnt.knee_angle, e.knee);
        if (jnt.reachable !== e.reach) report_mismatch("reachable", jnt.reachable, e.reach);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tgt.valid && tgt.ready) || (jnt.valid && jnt.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic add_target(longint x, longint z);
    target_t t;
    t.x = x[CoordW-1:0];
    t.z = z[CoordW-1:0];
    pending_targets.push_back(t);
  endtask

  task automatic wait_drained();
    while (pending_targets.size() > 0 || tgt.valid || expected_joints.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_lengths(logic [LenW-1:0] l1, logic [LenW-1:0] l2);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CfgThigh; cfg_data_i <= l1;
    @(posedge clk_i);
    cfg_idx_i <= CfgCalf; cfg_data_i <= l2;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    upper_len = l1;
    lower_len = l2;
  endtask

  task automatic add_random_target();
    longint unsigned lim;
    longint x, z;
    int mode;
    mode = $urandom_range(99);
    lim = upper_len + lower_len;
    if (lim > 64'd2147483647) lim = 64'd2147483647;
    if (lim == 0) lim = 1000;
    if (mode < 65) begin
      x = longint'($urandom_range(0, 32'(2 * lim))) - longint'(lim);
      z = longint'($urandom_range(0, 32'(2 * lim))) - longint'(lim);
    end else if (mode < 85) begin
      x = longint'(int'($urandom()));
      z = longint'(int'($urandom()));
    end else begin
      x = longint'($urandom_range(0, 200)) - 100;
      z = longint'($urandom_range(0, 200)) - 100;
    end
    add_target(x, z);
  endtask

  initial begin : stim
    logic [LenW-1:0] l1s[NumPhases];
    logic [LenW-1:0] l2s[NumPhases];
    l1s = '{31'd65536, 31'h7fffffff, 31'd1, 31'd0, 31'd98304, 31'h7fffffff,
            31'd100000, 31'd20000};
    l2s = '{31'd65536, 31'h7fffffff, 31'd1, 31'd65536, 31'd0, 31'd1,
            31'd30000, 31'd45000};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgThigh;
    cfg_data_i = '0;
    tgt.valid = 1'b0;
    tgt.target_x = '0;
    tgt.target_z = '0;
    jnt.ready = 1'b0;
    upper_len = 13107;
    lower_len = 13107;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 31;
    recv_stall_pct = 51;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_target(0, 0);
    add_target(0, -26214);
    add_target(26214, 0);
    add_target(26215, 0);
    add_target(0, 26214);
    add_target(-26214, 0);
    add_target(13107, -13107);
    add_target(-13107, 13107);
    add_target(18000, -18000);
    add_target(2147483647, 2147483647);
    add_target(-2147483648, -2147483648);
    add_target(-2147483648, 0);
    add_target(0, -2147483648);
    add_target(1, 0);
    add_target(-1, -1);
    repeat (PhaseItems) add_random_target();

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      if (p == 2) begin
        send_idle_pct = 51;
        recv_stall_pct = 31;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_lengths(l1s[p], l2s[p]);
      if (p == 0) begin
        add_target(0, 0);
        add_target(0, -131072);
        add_target(0, 131072);
        add_target(-131072, 0);
      end
      repeat (PhaseItems) add_random_target();
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
